FILE: src/tsf_pkg.sv
// Package for the scanline triangle fill block.
// Holds the fixed-point widths, config register indexes and the queued item type.
// No dependencies.
`timescale 1ns / 1ps
package tsf_pkg;

  localparam int COORD_W         = 24;
  localparam int COORD_FRAC_BITS = 8;
  localparam int SLOPE_FRAC_BITS = 16;
  localparam int SLOPE_W         = 40;
  localparam int SCREEN_DIM_BITS = 12;
  localparam int CFG_W           = 13;
  localparam int COLOR_W         = 32;
  // Working width for row and column positions (one bit of headroom)
  localparam int POS_W           = COORD_W + 1;

  // Config register indexes
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // Item kinds
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_STEP = 1'b1;

  typedef struct packed {
    logic                      kind;
    logic signed [COORD_W-1:0] v0x;
    logic signed [COORD_W-1:0] v0y;
    logic signed [COORD_W-1:0] v1x;
    logic signed [COORD_W-1:0] v1y;
    logic signed [COORD_W-1:0] v2x;
    logic signed [COORD_W-1:0] v2y;
    logic [COLOR_W-1:0]        color;
  } item_t;

  // Column/row truncated toward zero lies on the screen
  function automatic logic pix_ok(input logic signed [POS_W-1:0] v,
                                  input logic [CFG_W-1:0] lim);
    logic [POS_W-COORD_FRAC_BITS-1:0] t;
    logic                             neg_ok;
    t      = v[POS_W-1] ? '0 : v[POS_W-1:COORD_FRAC_BITS];
    neg_ok = v > -$signed(POS_W'(1 << COORD_FRAC_BITS));
    pix_ok = neg_ok && ({4'b0, t} < {{(POS_W-COORD_FRAC_BITS+4-CFG_W){1'b0}}, lim})
             && (t < (POS_W-COORD_FRAC_BITS)'(1 << SCREEN_DIM_BITS));
  endfunction

endpackage

FILE: src/triangle_scanline_fill_top.sv
// Top level of the scanline triangle fill block: config registers, queue and engine.
// Depends on tsf_pkg, tsf_front and tsf_back (which uses tsf_div).
`timescale 1ns / 1ps
// Usage:
//  Input channel (in_valid_i / in_stall_o): kind 0 loads a triangle (three
//  Q15.8 vertices and a color), kind 1 steps one sample. A two-entry queue
//  takes transactions while the engine works.
//  Output channel (out_valid_o / out_stall_i): one sample per active step,
//  with pixel_write and triangle_done. A step while idle yields nothing.
//  Config port: cfg_we_i writes screen width (index 0) or height (index 1).
//  Sequencing:
//  - A step whose span continues: one sample per cycle sustained unless the output stalls.
//  - A step that finishes a row: row setup (the long-edge and short-edge crossings
//    through a 25x20 multiplier as a low and a high partial product each),
//    plus a slope divide when the middle vertex is crossed.
//  - A load: two slope divides (40-step restoring divider), then row setup
//    when the triangle has rows.
//  The result register holds while out_stall_i is high; the engine waits for
//  it before issuing the next sample, the queue keeps accepting until full.
//  Reset empties the queue, drops any triangle and sets the screen to 640x480.
module triangle_scanline_fill_top import tsf_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       kind_i,
  input  logic signed [COORD_W-1:0]  vertex0_x_i,
  input  logic signed [COORD_W-1:0]  vertex0_y_i,
  input  logic signed [COORD_W-1:0]  vertex1_x_i,
  input  logic signed [COORD_W-1:0]  vertex1_y_i,
  input  logic signed [COORD_W-1:0]  vertex2_x_i,
  input  logic signed [COORD_W-1:0]  vertex2_y_i,
  input  logic [COLOR_W-1:0]         fill_rgba_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [SCREEN_DIM_BITS-1:0] pixel_x_o,
  output logic [SCREEN_DIM_BITS-1:0] pixel_y_o,
  output logic [COLOR_W-1:0]         pixel_color_o,
  output logic                       pixel_write_o,
  output logic                       triangle_done_o,
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [CFG_W-1:0]           cfg_wdata_i
);

  logic [CFG_W-1:0] width_q, height_q;
  item_t in_item, head;
  logic  full, push, pop, head_valid;

  // Config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CFG_W'(640);
      height_q <= CFG_W'(480);
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_WIDTH) width_q <= cfg_wdata_i;
      if (cfg_idx_i == REG_HEIGHT) height_q <= cfg_wdata_i;
    end
  end

  assign in_item = '{kind: kind_i, v0x: vertex0_x_i, v0y: vertex0_y_i,
                     v1x: vertex1_x_i, v1y: vertex1_y_i,
                     v2x: vertex2_x_i, v2y: vertex2_y_i, color: fill_rgba_i};
  assign in_stall_o = full;
  assign push       = in_valid_i && !full;

  tsf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .item_i       (in_item),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  tsf_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_valid_i    (head_valid),
    .head_i          (head),
    .pop_o           (pop),
    .width_i         (width_q),
    .height_i        (height_q),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .pixel_x_o       (pixel_x_o),
    .pixel_y_o       (pixel_y_o),
    .pixel_color_o   (pixel_color_o),
    .pixel_write_o   (pixel_write_o),
    .triangle_done_o (triangle_done_o)
  );

`ifndef SYNTH
  // A written pixel lies inside the screen
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pixel_write_o |->
      ({1'b0, pixel_x_o} < width_q) && ({1'b0, pixel_y_o} < height_q))
    else $error("pixel outside screen");

  // A sample that writes nothing carries zero fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !pixel_write_o |->
      pixel_x_o == '0 && pixel_y_o == '0 && pixel_color_o == '0)
    else $error("non-writing sample has payload");

  // A stalled sample stays valid and unchanged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(pixel_x_o) && $stable(pixel_y_o) &&
      $stable(pixel_color_o) && $stable(pixel_write_o) && $stable(triangle_done_o))
    else $error("stalled sample changed");

  // The queue is never popped when empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> head_valid)
    else $error("pop from empty queue");
`endif

endmodule

FILE: src/tsf_front.sv
// Front end of the triangle fill block: a two-entry transaction queue.
// Depends on tsf_pkg.
`timescale 1ns / 1ps
module tsf_front import tsf_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  head_valid_o,
  output item_t head_o
);

  item_t      mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o       = cnt_q == 2'd2;
  assign head_valid_o = cnt_q != 2'd0;
  assign head_o       = mem_q[rd_q];

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= item_i;
  end

endmodule

FILE: src/tsf_div.sv
// Edge slope divider: |dx| << SLOPE_FRAC_BITS / |dy|, one quotient bit per cycle.
// Saturates the magnitude and applies the sign. Depends on tsf_pkg.
`timescale 1ns / 1ps
module tsf_div import tsf_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic signed [COORD_W:0]   dx_i,
  input  logic signed [COORD_W:0]   dy_i,
  output logic                      done_o,
  output logic signed [SLOPE_W-1:0] slope_o
);

  localparam int NUM_W = COORD_W + SLOPE_FRAC_BITS;

  logic                 busy_q;
  logic [5:0]           cnt_q;
  logic [NUM_W-1:0]     num_q;
  logic [COORD_W-1:0]   rem_q, den_q;
  logic                 neg_q, zero_q, done_q;
  logic [COORD_W:0]     trial;
  logic signed [COORD_W+1:0] diff;
  logic [COORD_W:0]     mdx, mdy;
  logic [SLOPE_W-1:0]   sat;

  assign mdx   = dx_i[COORD_W] ? -dx_i : dx_i;
  assign mdy   = dy_i[COORD_W] ? -dy_i : dy_i;
  assign trial = {rem_q, num_q[NUM_W-1]};
  assign diff  = $signed({1'b0, trial}) - $signed({2'b0, den_q});

  // Restoring division step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'(NUM_W - 1);
      end else if (busy_q) begin
        if (cnt_q == 6'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        cnt_q <= cnt_q - 6'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q  <= {mdx[COORD_W-1:0], {SLOPE_FRAC_BITS{1'b0}}};
      den_q  <= mdy[COORD_W-1:0];
      rem_q  <= '0;
      neg_q  <= dx_i[COORD_W] != dy_i[COORD_W];
      zero_q <= dy_i == '0;
    end else if (busy_q) begin
      if (!diff[COORD_W+1]) begin
        rem_q <= diff[COORD_W-1:0];
        num_q <= {num_q[NUM_W-2:0], 1'b1};
      end else begin
        rem_q <= trial[COORD_W-1:0];
        num_q <= {num_q[NUM_W-2:0], 1'b0};
      end
    end
  end

  // Saturate to 2^39 - 1, then sign
  assign sat     = num_q[NUM_W-1] ? {1'b0, {(SLOPE_W-1){1'b1}}} : num_q;
  assign done_o  = done_q;
  assign slope_o = zero_q ? '0 : (neg_q ? -$signed(sat) : $signed(sat));

endmodule

FILE: src/tsf_back.sv
// Back end of the triangle fill block: setup, row/span walking and the result register.
// Depends on tsf_pkg and tsf_div.
`timescale 1ns / 1ps
module tsf_back import tsf_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       head_valid_i,
  input  item_t                      head_i,
  output logic                       pop_o,
  input  logic [CFG_W-1:0]           width_i,
  input  logic [CFG_W-1:0]           height_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [SCREEN_DIM_BITS-1:0] pixel_x_o,
  output logic [SCREEN_DIM_BITS-1:0] pixel_y_o,
  output logic [COLOR_W-1:0]         pixel_color_o,
  output logic                       pixel_write_o,
  output logic                       triangle_done_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DST  = 4'd1;
  localparam logic [3:0] S_DIV  = 4'd2;
  localparam logic [3:0] S_ROW  = 4'd3;
  localparam logic [3:0] S_OFF  = 4'd4;
  localparam logic [3:0] S_MLO  = 4'd5;
  localparam logic [3:0] S_MHI  = 4'd6;
  localparam logic [3:0] S_SUM  = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;

  localparam logic [1:0] T_LONG = 2'd0;
  localparam logic [1:0] T_S01  = 2'd1;
  localparam logic [1:0] T_S12  = 2'd2;

  localparam int ML_W  = 20;
  localparam int UO_W  = COORD_W + 1;
  localparam int PR_W  = 64;
  localparam int RES_W = PR_W - SLOPE_FRAC_BITS + 2;
  localparam logic signed [POS_W-1:0] ONE_PIX = POS_W'(1 << COORD_FRAC_BITS);

  logic [3:0] state_q, state_d;
  logic [1:0] tgt_q, tgt_d;
  logic signed [COORD_W-1:0] vx_q [3], vy_q [3], vx_d [3], vy_d [3];
  logic signed [SLOPE_W-1:0] long_q, long_d, short_q, short_d;
  logic signed [POS_W-1:0]   row_q, row_d, col_q, col_d, end_q, end_d;
  logic lower_q, lower_d, active_q, active_d, edge_q, edge_d;
  logic [COLOR_W-1:0] color_q, color_d;
  logic signed [COORD_W-1:0] xa_q, xa_d;
  logic [UO_W-1:0]  uo_q, uo_d;
  logic             eneg_q, eneg_d;
  logic [UO_W+ML_W-1:0] lo_q, lo_d;
  logic [UO_W+SLOPE_W-1-ML_W-1:0] hi_q, hi_d;
  logic [PR_W-1:0]  prod_q, prod_d;

  logic out_valid_q, out_valid_d, write_q, write_d, done_q, done_d;
  logic [SCREEN_DIM_BITS-1:0] px_q, px_d, py_q, py_d;
  logic [COLOR_W-1:0] pc_q, pc_d;

  logic div_start, div_done;
  logic signed [COORD_W:0] div_dx, div_dy;
  logic signed [SLOPE_W-1:0] div_slope;

  // Edge operand select
  logic signed [COORD_W-1:0] bx, by;
  logic signed [SLOPE_W-1:0] slope;
  logic [SLOPE_W-2:0]        ms;

  always_comb begin
    if (edge_q) begin
      bx = vx_q[0]; by = vy_q[0]; slope = long_q;
    end else if (lower_q) begin
      bx = vx_q[1]; by = vy_q[1]; slope = short_q;
    end else begin
      bx = vx_q[0]; by = vy_q[0]; slope = short_q;
    end
  end
  assign ms = slope[SLOPE_W-1] ? (SLOPE_W-1)'(-slope) : slope[SLOPE_W-2:0];

  // Divider operands from the selected edge
  always_comb begin
    unique case (tgt_q)
      T_LONG: begin
        div_dx = {vx_q[2][COORD_W-1], vx_q[2]} - {vx_q[0][COORD_W-1], vx_q[0]};
        div_dy = {vy_q[2][COORD_W-1], vy_q[2]} - {vy_q[0][COORD_W-1], vy_q[0]};
      end
      T_S01: begin
        div_dx = {vx_q[1][COORD_W-1], vx_q[1]} - {vx_q[0][COORD_W-1], vx_q[0]};
        div_dy = {vy_q[1][COORD_W-1], vy_q[1]} - {vy_q[0][COORD_W-1], vy_q[0]};
      end
      default: begin
        div_dx = {vx_q[2][COORD_W-1], vx_q[2]} - {vx_q[1][COORD_W-1], vx_q[1]};
        div_dy = {vy_q[2][COORD_W-1], vy_q[2]} - {vy_q[1][COORD_W-1], vy_q[1]};
      end
    endcase
  end
  assign div_start = state_q == S_DST;

  tsf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .dx_i    (div_dx),
    .dy_i    (div_dy),
    .done_o  (div_done),
    .slope_o (div_slope)
  );

  logic out_free;
  assign out_free = !out_valid_q || !out_stall_i;
  assign pop_o    = (state_q == S_IDLE) && head_valid_i && out_free;

  // Main sequencer
  always_comb begin
    logic signed [COORD_W-1:0] sx [3], sy [3], tx, ty;
    logic signed [POS_W-1:0]   vy2, vy1, coln, rown;
    logic signed [POS_W:0]     off;
    logic [POS_W:0]            moff;
    logic [PR_W:0]             rnd;
    logic signed [RES_W-1:0]   res, xs;
    logic signed [COORD_W-1:0] x;

    state_d = state_q; tgt_d = tgt_q;
    vx_d = vx_q; vy_d = vy_q;
    long_d = long_q; short_d = short_q;
    row_d = row_q; col_d = col_q; end_d = end_q;
    lower_d = lower_q; active_d = active_q; edge_d = edge_q;
    color_d = color_q; xa_d = xa_q; uo_d = uo_q; eneg_d = eneg_q;
    lo_d = lo_q; hi_d = hi_q; prod_d = prod_q;
    out_valid_d = out_valid_q && out_stall_i;
    write_d = write_q; done_d = done_q; px_d = px_q; py_d = py_q; pc_d = pc_q;
    tx = '0; ty = '0;

    vy2  = {vy_q[2][COORD_W-1], vy_q[2]};
    vy1  = {vy_q[1][COORD_W-1], vy_q[1]};
    coln = col_q + ONE_PIX;
    rown = row_q + ONE_PIX;
    off  = {row_q[POS_W-1], row_q} - {{2{by[COORD_W-1]}}, by};
    moff = off[POS_W] ? -off : off;
    rnd  = {1'b0, prod_q} + (PR_W+1)'((1 << SLOPE_FRAC_BITS) - 1);
    if (eneg_q && prod_q != '0)
      res = -$signed(RES_W'(rnd[PR_W:SLOPE_FRAC_BITS]));
    else
      res = $signed(RES_W'(prod_q[PR_W-1:SLOPE_FRAC_BITS]));
    xs = res + {{(RES_W-COORD_W){bx[COORD_W-1]}}, bx};
    if (xs > RES_W'((1 << (COORD_W-1)) - 1)) x = {1'b0, {(COORD_W-1){1'b1}}};
    else if (xs < -$signed(RES_W'(1 << (COORD_W-1)))) x = {1'b1, {(COORD_W-1){1'b0}}};
    else x = xs[COORD_W-1:0];
    sx[0] = head_i.v0x; sy[0] = head_i.v0y;
    sx[1] = head_i.v1x; sy[1] = head_i.v1y;
    sx[2] = head_i.v2x; sy[2] = head_i.v2y;

    unique case (state_q)
      S_IDLE: begin
        if (pop_o) begin
          if (head_i.kind == KIND_LOAD) begin
            // Sort vertices by y
            if (sy[1] < sy[0]) begin
              tx = sx[0]; ty = sy[0]; sx[0] = sx[1]; sy[0] = sy[1]; sx[1] = tx; sy[1] = ty;
            end
            if (sy[2] < sy[0]) begin
              tx = sx[0]; ty = sy[0]; sx[0] = sx[2]; sy[0] = sy[2]; sx[2] = tx; sy[2] = ty;
            end
            if (sy[2] < sy[1]) begin
              tx = sx[1]; ty = sy[1]; sx[1] = sx[2]; sy[1] = sy[2]; sx[2] = tx; sy[2] = ty;
            end
            vx_d = sx; vy_d = sy;
            lower_d  = 1'b0;
            row_d    = {sy[0][COORD_W-1], sy[0]};
            col_d    = '0;
            end_d    = '0;
            color_d  = head_i.color;
            active_d = 1'b1;
            tgt_d    = T_LONG;
            state_d  = S_DST;
          end else if (active_q) begin
            out_valid_d = 1'b1;
            write_d = 1'b0; done_d = 1'b0;
            px_d = '0; py_d = '0; pc_d = '0;
            if (row_q >= vy2) begin
              done_d   = 1'b1;
              active_d = 1'b0;
            end else begin
              if (col_q < end_q) begin
                if (pix_ok(col_q, width_i) && pix_ok(row_q, height_i)) begin
                  // Sub-pixel negative positions truncate to zero
                  write_d = 1'b1;
                  px_d = col_q[POS_W-1] ? '0 : col_q[COORD_FRAC_BITS +: SCREEN_DIM_BITS];
                  py_d = row_q[POS_W-1] ? '0 : row_q[COORD_FRAC_BITS +: SCREEN_DIM_BITS];
                  pc_d = color_q;
                end
                col_d = coln;
              end
              if (!(col_q < end_q) || !(coln < end_q)) begin
                row_d = rown;
                if (rown >= vy2) begin
                  done_d   = 1'b1;
                  active_d = 1'b0;
                end else begin
                  state_d = S_ROW;
                end
              end
            end
          end
        end
      end
      S_DST: state_d = S_DIV;
      S_DIV: begin
        if (div_done) begin
          unique case (tgt_q)
            T_LONG: begin
              long_d  = div_slope;
              tgt_d   = T_S01;
              state_d = S_DST;
            end
            T_S01: begin
              short_d = div_slope;
              state_d = (row_q < vy2) ? S_ROW : S_IDLE;
            end
            default: begin
              short_d = div_slope;
              state_d = S_ROW;
            end
          endcase
        end
      end
      S_ROW: begin
        // Switch to the lower short edge at the middle vertex
        if (!lower_q && !(row_q < vy1)) begin
          lower_d = 1'b1;
          tgt_d   = T_S12;
          state_d = S_DST;
        end else begin
          edge_d  = 1'b0;
          state_d = S_OFF;
        end
      end
      S_OFF: begin
        uo_d   = (moff > (POS_W+1)'(1 << COORD_W)) ? UO_W'(1 << COORD_W) : moff[UO_W-1:0];
        eneg_d = off[POS_W] != slope[SLOPE_W-1];
        state_d = S_MLO;
      end
      S_MLO: begin
        lo_d    = uo_q * ms[ML_W-1:0];
        state_d = S_MHI;
      end
      S_MHI: begin
        hi_d    = uo_q * ms[SLOPE_W-2:ML_W];
        state_d = S_SUM;
      end
      S_SUM: begin
        prod_d  = PR_W'(lo_q) + {hi_q, {ML_W{1'b0}}};
        state_d = S_FIN;
      end
      S_FIN: begin
        if (!edge_q) begin
          xa_d    = x;
          edge_d  = 1'b1;
          state_d = S_OFF;
        end else begin
          // Span from the smaller crossing to the larger
          if (xa_q > x) begin
            col_d = {x[COORD_W-1], x};
            end_d = {xa_q[COORD_W-1], xa_q};
          end else begin
            col_d = {xa_q[COORD_W-1], xa_q};
            end_d = {x[COORD_W-1], x};
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      tgt_q       <= T_LONG;
      vx_q        <= '{default: '0};
      vy_q        <= '{default: '0};
      long_q      <= '0;
      short_q     <= '0;
      row_q       <= '0;
      col_q       <= '0;
      end_q       <= '0;
      lower_q     <= 1'b0;
      active_q    <= 1'b0;
      edge_q      <= 1'b0;
      color_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tgt_q       <= tgt_d;
      vx_q        <= vx_d;
      vy_q        <= vy_d;
      long_q      <= long_d;
      short_q     <= short_d;
      row_q       <= row_d;
      col_q       <= col_d;
      end_q       <= end_d;
      lower_q     <= lower_d;
      active_q    <= active_d;
      edge_q      <= edge_d;
      color_q     <= color_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath and result payload
  always_ff @(posedge clk_i) begin
    xa_q    <= xa_d;
    uo_q    <= uo_d;
    eneg_q  <= eneg_d;
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    prod_q  <= prod_d;
    write_q <= write_d;
    done_q  <= done_d;
    px_q    <= px_d;
    py_q    <= py_d;
    pc_q    <= pc_d;
  end

  assign out_valid_o     = out_valid_q;
  assign pixel_x_o       = px_q;
  assign pixel_y_o       = py_q;
  assign pixel_color_o   = pc_q;
  assign pixel_write_o   = write_q;
  assign triangle_done_o = done_q;

endmodule
